// File: rtl/core/usr_pkg.sv
// ----------------------------------------------------------------------------
// usr_pkg: shared types and constants for the ultrasonic ranger controller
// Phase codes, register indexes, reset values and the echo-to-distance ratio.
// ----------------------------------------------------------------------------
package usr_pkg;

  // Echo counter width default (ticks while echo is high)
  localparam int COUNT_BITS_DEF = 16;

  // Distance in whole centimetres
  localparam int DIST_BITS = 14;
  localparam logic [DIST_BITS-1:0] DIST_MAX   = '1;
  localparam logic [DIST_BITS-1:0] DIST_RESET = 14'd10000;

  // distance = floor(ticks * DIST_NUM / DIST_DEN), i.e. 10/58 cm per 10 us tick
  localparam int REM_BITS = 5;
  localparam logic [REM_BITS:0] DIST_NUM = 6'd5;
  localparam logic [REM_BITS:0] DIST_DEN = 6'd29;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAIT_TICKS    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_TICKS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MID_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_LIMIT     = 3'd4;

  localparam int WAIT_BITS = 16;
  localparam int TRIG_BITS = 8;
  localparam logic [WAIT_BITS-1:0] WAIT_TICKS_RESET    = 16'd10004;
  localparam logic [TRIG_BITS-1:0] TRIGGER_TICKS_RESET = 8'd1;
  localparam logic [DIST_BITS-1:0] NEAR_LIMIT_RESET    = 14'd5;
  localparam logic [DIST_BITS-1:0] MID_LIMIT_RESET     = 14'd10;
  localparam logic [DIST_BITS-1:0] FAR_LIMIT_RESET     = 14'd15;

  // Active-low LED bar patterns, one lit LED per band
  localparam logic [3:0] LED_NEAR = 4'hE;
  localparam logic [3:0] LED_MID  = 4'hD;
  localparam logic [3:0] LED_FAR  = 4'hB;
  localparam logic [3:0] LED_OUT  = 4'h7;

  // Stream widths
  localparam int S_TDATA_BITS = 8;
  localparam int M_TDATA_BITS = 24;

  typedef enum logic [2:0] {
    PH_WAIT      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_ARMED     = 3'd3,
    PH_COUNT     = 3'd4
  } phase_t;

  // Control from the sequencer to the echo accumulator
  typedef struct packed {
    logic clear;  // rising echo edge: restart the measurement
    logic step;   // echo still high: one more tick
  } acc_ctrl_t;

endpackage

// File: rtl/core/usr_echo_acc.sv
// ----------------------------------------------------------------------------
// usr_echo_acc: echo width accumulator
// Counts echo ticks (saturating) and keeps ticks*5/29 as a running quotient
// and remainder, so the distance is ready the tick the echo falls.
// ----------------------------------------------------------------------------
module usr_echo_acc #(
  parameter int COUNT_BITS = usr_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  usr_pkg::acc_ctrl_t           ctrl,
  output logic [usr_pkg::DIST_BITS-1:0] dist_cm
);
  import usr_pkg::*;

  logic [COUNT_BITS-1:0] count;
  logic [REM_BITS-1:0]   rem;
  logic [DIST_BITS-1:0]  quot;

  logic [REM_BITS:0]     rem_sum;
  logic                  wrap;
  logic [REM_BITS-1:0]   rem_next;
  logic [DIST_BITS-1:0]  quot_next;

  // remainder stays below 29, so one compare and subtract per tick
  always_comb begin
    rem_sum   = {1'b0, rem} + DIST_NUM;
    wrap      = (rem_sum >= DIST_DEN);
    rem_next  = wrap ? REM_BITS'(rem_sum - DIST_DEN) : rem_sum[REM_BITS-1:0];
    quot_next = (wrap && (quot != DIST_MAX)) ? quot + 1'b1 : quot;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
      rem   <= '0;
      quot  <= '0;
    end else if (ctrl.step && !(&count)) begin
      count <= count + 1'b1;
      rem   <= rem_next;
      quot  <= quot_next;
    end
  end

  assign dist_cm = quot;

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, rem} < DIST_DEN)
    else $error("echo remainder out of range");

  a_sat_hold: assert property (@(posedge clk) disable iff (rst)
    (&count) && !ctrl.clear |=> (&count) && $stable(quot))
    else $error("saturated echo count moved");
`endif

endmodule

// File: rtl/core/ultrasonic_ranger_controller.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_controller: HC-SR04 style ranging sequencer
// One input transaction per 10 us tick; one result transaction per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one 10 us tick carrying the sampled echo level.
// The sequencer waits wait_ticks ticks, drives the trigger low for one tick
// and high for trigger_ticks ticks, then listens for a rising echo edge and
// counts ticks while the echo stays high (saturating, no timeout). On the
// falling edge the distance floor(ticks*5/29) cm is stored and measure_done
// is flagged for that tick. Every tick returns one result: trigger level,
// the active-low LED bar band of the stored distance, the stored distance
// and the done flag. Zero wait or trigger lengths act as one. Throughput is
// one tick per clock: state and result are computed in a single pass at the
// input transaction and land in an output register; a one-entry skid
// register behind it keeps s_tready high while a result waits, so only a
// second unaccepted result stalls the input. The distance divide is a
// running quotient kept while the echo is counted, so no divider sits in
// the path.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_controller #(
  parameter int COUNT_BITS = usr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [usr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [usr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // tick stream in
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [usr_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [0] echo_level, [7:1] zero
  // result stream out
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] trigger_out, [4:1] led_bar_n, [18:5] distance_cm, [19] measure_done,
  // [23:20] zero
  output logic [usr_pkg::M_TDATA_BITS-1:0]  m_tdata
);
  import usr_pkg::*;

  // ---------------- configuration registers ----------------
  logic [WAIT_BITS-1:0] wait_ticks;
  logic [TRIG_BITS-1:0] trigger_ticks;
  logic [DIST_BITS-1:0] near_limit;
  logic [DIST_BITS-1:0] mid_limit;
  logic [DIST_BITS-1:0] far_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks    <= WAIT_TICKS_RESET;
      trigger_ticks <= TRIGGER_TICKS_RESET;
      near_limit    <= NEAR_LIMIT_RESET;
      mid_limit     <= MID_LIMIT_RESET;
      far_limit     <= FAR_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_TICKS:    wait_ticks    <= cfg_data[WAIT_BITS-1:0];
        CFG_TRIGGER_TICKS: trigger_ticks <= cfg_data[TRIG_BITS-1:0];
        CFG_NEAR_LIMIT:    near_limit    <= cfg_data[DIST_BITS-1:0];
        CFG_MID_LIMIT:     mid_limit     <= cfg_data[DIST_BITS-1:0];
        CFG_FAR_LIMIT:     far_limit     <= cfg_data[DIST_BITS-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------- handshakes ----------------
  logic accept;
  logic take;
  logic out_valid;
  logic skid_valid;
  logic [M_TDATA_BITS-1:0] out_data;
  logic [M_TDATA_BITS-1:0] skid_data;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign take     = out_valid && m_tready;

  // ---------------- sequencer state ----------------
  phase_t               phase;
  phase_t               phase_next;
  logic [WAIT_BITS-1:0] wait_count;
  logic [WAIT_BITS-1:0] wait_count_next;
  logic                 last_echo;
  logic [DIST_BITS-1:0] stored_distance;
  logic [DIST_BITS-1:0] stored_distance_next;

  logic                 echo;
  logic [WAIT_BITS-1:0] wait_len;
  logic [TRIG_BITS-1:0] trig_len;
  logic [WAIT_BITS:0]   wait_inc;
  logic                 wait_end;
  logic                 trig_end;
  logic                 echo_rise;
  logic                 trig;
  logic                 done;
  acc_ctrl_t            acc_ctrl;
  logic [DIST_BITS-1:0] acc_dist;
  logic [3:0]           led_bar;
  logic [M_TDATA_BITS-1:0] result;

  assign echo      = s_tdata[0];
  // a length of zero behaves as one
  assign wait_len  = (wait_ticks == '0) ? WAIT_BITS'(1) : wait_ticks;
  assign trig_len  = (trigger_ticks == '0) ? TRIG_BITS'(1) : trigger_ticks;
  assign wait_inc  = {1'b0, wait_count} + 1'b1;
  assign wait_end  = (wait_inc >= {1'b0, wait_len});
  assign trig_end  = (wait_inc >= (WAIT_BITS+1)'(trig_len));
  // an echo already high when listening starts is not an edge
  assign echo_rise = echo && !last_echo;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_WAIT:      if (wait_end)  phase_next = PH_TRIG_LOW;
      PH_TRIG_LOW:                 phase_next = PH_TRIG_HIGH;
      PH_TRIG_HIGH: if (trig_end)  phase_next = PH_ARMED;
      PH_ARMED:     if (echo_rise) phase_next = PH_COUNT;
      PH_COUNT:     if (!echo)     phase_next = PH_WAIT;
      default:                     phase_next = PH_WAIT;
    endcase
  end

  // per-tick outputs and counter updates
  always_comb begin
    wait_count_next      = '0;
    stored_distance_next = stored_distance;
    acc_ctrl             = '0;
    trig                 = 1'b0;
    done                 = 1'b0;
    case (phase)
      PH_WAIT: begin
        if (!wait_end) wait_count_next = wait_inc[WAIT_BITS-1:0];
      end
      PH_TRIG_LOW: ;
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        if (!trig_end) wait_count_next = wait_inc[WAIT_BITS-1:0];
      end
      PH_ARMED: begin
        wait_count_next = wait_count;
        acc_ctrl.clear  = accept && echo_rise;
      end
      PH_COUNT: begin
        wait_count_next = wait_count;
        if (echo) begin
          acc_ctrl.step = accept;
        end else begin
          stored_distance_next = acc_dist;
          done                 = 1'b1;
          wait_count_next      = '0;
        end
      end
      default: ;
    endcase
  end

  // band of the distance after this tick; first limit met wins
  always_comb begin
    if (stored_distance_next < near_limit)     led_bar = LED_NEAR;
    else if (stored_distance_next < mid_limit) led_bar = LED_MID;
    else if (stored_distance_next < far_limit) led_bar = LED_FAR;
    else                                       led_bar = LED_OUT;
  end

  assign result = {(M_TDATA_BITS-DIST_BITS-6)'(0), done, stored_distance_next,
                   led_bar, trig};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      wait_count      <= '0;
      last_echo       <= 1'b0;
      stored_distance <= DIST_RESET;
    end else if (accept) begin
      phase           <= phase_next;
      wait_count      <= wait_count_next;
      last_echo       <= echo;
      stored_distance <= stored_distance_next;
    end
  end

  usr_echo_acc #(
    .COUNT_BITS (COUNT_BITS)
  ) u_echo_acc (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (acc_ctrl),
    .dist_cm (acc_dist)
  );

  // ---------------- output register + skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_measure_ends: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == PH_COUNT) && !echo |=> (phase == PH_WAIT) && (wait_count == '0))
    else $error("falling echo did not return to wait");

  a_trig_follows_low: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == PH_TRIG_LOW) |=> (phase == PH_TRIG_HIGH))
    else $error("trigger low tick not followed by trigger high");

  a_hold_no_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(stored_distance))
    else $error("sequencer state moved without an input transaction");
`endif

endmodule

// File: verif/ultrasonic_ranger_checker.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_checker: result predictor and comparator
// Watches the config port and both streams. It keeps its own copy of the
// ranging sequencer and compares every result transaction, field by field.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_checker #(
  parameter int COUNT_BITS = usr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [usr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [usr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [usr_pkg::S_TDATA_BITS-1:0]  s_tdata,  // [0] echo_level, [7:1] zero
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] trigger_out, [4:1] led_bar_n, [18:5] distance_cm, [19] measure_done,
  // [23:20] zero
  input  logic [usr_pkg::M_TDATA_BITS-1:0]  m_tdata,
  output int                                errors,
  output int                                pending,
  output int                                measurements
);
  import usr_pkg::*;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic                 trigger;
    logic [3:0]           led_bar_n;
    logic [DIST_BITS-1:0] distance_cm;
    logic                 measure_done;
  } reading_t;

  // configuration copy
  logic [WAIT_BITS-1:0] wait_len;
  logic [TRIG_BITS-1:0] trig_len;
  logic [DIST_BITS-1:0] near_cm, mid_cm, far_cm;

  // sequencer copy
  phase_t               phase;
  logic [WAIT_BITS-1:0] tick_count;   // wait ticks, also trigger-high ticks
  logic [COUNT_BITS-1:0] echo_ticks;
  logic                 prev_echo;
  logic [DIST_BITS-1:0] distance;

  reading_t awaited_readings[$];
  int       readings_seen;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (errors < PRINT_CAP)
      $display("mismatch on reading %0d, %s: got %0d, expected %0d",
               readings_seen, what, got, want);
    errors++;
  endtask

  function automatic logic [3:0] band_of(input logic [DIST_BITS-1:0] d);
    if (d < near_cm) return LED_NEAR;
    if (d < mid_cm) return LED_MID;
    if (d < far_cm) return LED_FAR;
    return LED_OUT;
  endfunction

  // One 10 us tick of the ranging sequencer; updates the copy of the state.
  function automatic reading_t range_tick(input logic echo);
    reading_t          r;
    int unsigned       wlen;
    int unsigned       tlen;
    longint unsigned   dist_full;
    wlen = (wait_len == '0) ? 32'd1 : 32'(wait_len);
    tlen = (trig_len == '0) ? 32'd1 : 32'(trig_len);
    r.trigger      = (phase == PH_TRIG_HIGH);
    r.measure_done = 1'b0;
    case (phase)
      PH_WAIT: begin
        if (32'(tick_count) + 32'd1 >= wlen) begin
          tick_count = '0;
          phase      = PH_TRIG_LOW;
        end else begin
          tick_count = tick_count + 1'b1;
        end
      end
      PH_TRIG_LOW: begin
        tick_count = '0;
        phase      = PH_TRIG_HIGH;
      end
      PH_TRIG_HIGH: begin
        if (32'(tick_count) + 32'd1 >= tlen) begin
          tick_count = '0;
          phase      = PH_ARMED;
        end else begin
          tick_count = tick_count + 1'b1;
        end
      end
      PH_ARMED: begin
        if (echo && !prev_echo) begin
          echo_ticks = '0;
          phase      = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_ticks != '1) echo_ticks = echo_ticks + 1'b1;
        end else begin
          dist_full = (64'(echo_ticks) * 64'(DIST_NUM)) / 64'(DIST_DEN);
          distance  = (dist_full > 64'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_BITS-1:0];
          r.measure_done = 1'b1;
          tick_count = '0;
          phase      = PH_WAIT;
        end
      end
      default: begin
        tick_count = '0;
        phase      = PH_WAIT;
      end
    endcase
    prev_echo     = echo;
    r.led_bar_n   = band_of(distance);
    r.distance_cm = distance;
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    reading_t next;
    if (rst) begin
      wait_len     = WAIT_TICKS_RESET;
      trig_len     = TRIGGER_TICKS_RESET;
      near_cm      = NEAR_LIMIT_RESET;
      mid_cm       = MID_LIMIT_RESET;
      far_cm       = FAR_LIMIT_RESET;
      phase        = PH_WAIT;
      tick_count   = '0;
      echo_ticks   = '0;
      prev_echo    = 1'b0;
      distance     = DIST_RESET;
      measurements = 0;
      readings_seen = 0;
      awaited_readings.delete();
    end else begin
      // result side first: a result can never belong to this edge's tick
      if (m_tvalid && m_tready) begin
        got.trigger      = m_tdata[0];
        got.led_bar_n    = m_tdata[4:1];
        got.distance_cm  = m_tdata[18:5];
        got.measure_done = m_tdata[19];
        if (awaited_readings.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_tdata, 0);
        end else begin
          want = awaited_readings.pop_front();
          if (got.trigger !== want.trigger)
            report_mismatch("trigger_out", got.trigger, want.trigger);
          if (got.led_bar_n !== want.led_bar_n)
            report_mismatch("led_bar_n", got.led_bar_n, want.led_bar_n);
          if (got.distance_cm !== want.distance_cm)
            report_mismatch("distance_cm", got.distance_cm, want.distance_cm);
          if (got.measure_done !== want.measure_done)
            report_mismatch("measure_done", got.measure_done, want.measure_done);
        end
        if (m_tdata[23:20] !== 4'h0) report_mismatch("tdata padding", m_tdata[23:20], 0);
        readings_seen++;
      end
      // a tick on the same edge as a write still sees the old settings
      if (s_tvalid && s_tready) begin
        next = range_tick(s_tdata[0]);
        if (next.measure_done) measurements++;
        awaited_readings.push_back(next);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAIT_TICKS:    wait_len = cfg_data[WAIT_BITS-1:0];
          CFG_TRIGGER_TICKS: trig_len = cfg_data[TRIG_BITS-1:0];
          CFG_NEAR_LIMIT:    near_cm  = cfg_data[DIST_BITS-1:0];
          CFG_MID_LIMIT:     mid_cm   = cfg_data[DIST_BITS-1:0];
          CFG_FAR_LIMIT:     far_cm   = cfg_data[DIST_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending = awaited_readings.size();
  end

endmodule

// File: verif/ultrasonic_ranger_controller_test.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_controller_test: top of the ranging controller bench
// Drives echo ticks and register settings, idles both streams at random and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_controller_test;
  import usr_pkg::*;

  localparam int IDLE_PCT        = 28;     // idle cycles per hundred, each side
  localparam int QUIET_LIMIT     = 5000;   // cycles with no transaction at all
  localparam int LONG_ECHO_TICKS = 200;    // one long echo pulse, unbroken
  localparam int NOISE_PCT       = 15;     // share of lone random echo ticks
  localparam int SETTINGS_COUNT  = 8;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [S_TDATA_BITS-1:0]  s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [M_TDATA_BITS-1:0]  m_tdata;

  int errors;
  int pending;
  int measurements;

  bit steady;          // no idling on either side while set
  int ticks_sent;
  int settings_used;
  int low_burst_max;   // longest run of low echo ticks in a random pulse
  int high_burst_max;  // longest echo pulse in ticks
  int quiet_cycles;

  // 12 time unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ultrasonic_ranger_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  ultrasonic_ranger_checker ranging_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .errors       (errors),
    .pending      (pending),
    .measurements (measurements)
  );

  // Receiver back-pressure: random stalls unless in the steady stretch
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: any transaction on either stream restarts the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // One tick transaction. Random idle cycles go in front; tvalid stays high
  // from one tick to the next when no idle falls between them.
  task automatic send_tick(input logic echo);
    while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_BITS-1){1'b0}}, echo};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  // Sender holds off until the checker has seen every result, then allows
  // the output registers a little slack before anything else happens.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes all five registers, one per cycle. Bits above each register's
  // width carry random junk, which the block must drop.
  task automatic load_registers(input int w, input int t, input int n, input int m,
                                input int f);
    logic [CFG_IDX_BITS-1:0]  idx[5];
    logic [CFG_DATA_BITS-1:0] val[5];
    idx = '{CFG_WAIT_TICKS, CFG_TRIGGER_TICKS, CFG_NEAR_LIMIT, CFG_MID_LIMIT,
            CFG_FAR_LIMIT};
    val[0] = w[WAIT_BITS-1:0];
    val[1] = {8'($urandom), t[TRIG_BITS-1:0]};
    val[2] = {2'($urandom), n[DIST_BITS-1:0]};
    val[3] = {2'($urandom), m[DIST_BITS-1:0]};
    val[4] = {2'($urandom), f[DIST_BITS-1:0]};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly whole echo pulses (a low run of one to low_burst_max ticks, then
  // a high run), salted with lone random ticks.
  task automatic run_random(input int count);
    int sent;
    int lo;
    int hi;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < NOISE_PCT) begin
        send_tick($urandom_range(1));
        sent++;
      end else begin
        lo = $urandom_range(low_burst_max, 1);
        hi = $urandom_range(high_burst_max, 0);
        repeat (lo) send_tick(1'b0);
        repeat (hi) send_tick(1'b1);
        sent += lo + hi;
      end
    end
  endtask

  initial begin
    int w;
    int t;
    int n;
    int m;
    int f;
    int items;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_WAIT_TICKS;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    steady    <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings first (long wait, stored distance beyond far)
    send_tick(1'b1);
    send_tick(1'b0);
    drain_results();

    // Zero wait and trigger lengths act as one; bands at their extremes.
    // The long wait counter from reset is already past the new length.
    load_registers(0, 0, 0, DIST_MAX, DIST_MAX);
    // echo already high when listening starts: no rising edge
    repeat (5) send_tick(1'b1);
    // zero-length pulse: rise and fall on consecutive ticks
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    // re-arm, then a short pulse
    repeat (3) send_tick(1'b0);
    repeat (12) send_tick(1'b1);
    send_tick(1'b0);

    // Random part, one register setting per pass
    for (int ph = 0; ph < SETTINGS_COUNT; ph++) begin
      drain_results();
      case (ph)
        0: begin  // ordinary ranging, all four bands reachable
          w = $urandom_range(12, 2);
          t = $urandom_range(4, 1);
          n = $urandom_range(6, 2);
          m = n + $urandom_range(6, 1);
          f = m + $urandom_range(6, 1);
          low_burst_max = w + t + 6;  high_burst_max = 120;  items = 250;
        end
        1: begin  // zero everywhere: all limits met at once
          w = 0;  t = 0;  n = 0;  m = 0;  f = 0;
          low_burst_max = 6;  high_burst_max = 60;  items = 150;
        end
        2: begin  // top of every range; stays in the wait phase
          w = 16'hFFFF;  t = 8'hFF;  n = DIST_MAX;  m = DIST_MAX;  f = DIST_MAX;
          low_burst_max = 4;  high_burst_max = 4;  items = 60;
        end
        3: begin  // wait shrunk below the running count; longest trigger
          w = 3;  t = 8'hFF;
          n = $urandom_range(8);
          m = n + $urandom_range(8);
          f = m + $urandom_range(8);
          low_burst_max = 300;  high_burst_max = 150;  items = 250;
        end
        4: begin  // band limits out of order, in a stretch with no idling
          steady <= 1'b1;
          w = $urandom_range(30, 1);
          t = $urandom_range(8, 1);
          n = $urandom_range(25, 10);
          m = $urandom_range(9);
          f = $urandom_range(30);
          low_burst_max = w + t + 6;  high_burst_max = 150;  items = 250;
        end
        5: begin  // one long echo; near limit at the top
          steady <= 1'b1;
          w = 1;  t = 1;  n = DIST_MAX;  m = 0;  f = 0;
          low_burst_max = 4;  high_burst_max = 4;  items = 0;
        end
        6: begin
          steady <= 1'b0;
          w = $urandom_range(40, 1);
          t = $urandom_range(10, 1);
          n = $urandom_range(40);
          m = $urandom_range(40);
          f = $urandom_range(40);
          low_burst_max = w + t + 6;  high_burst_max = 150;  items = 200;
        end
        default: begin
          w = $urandom_range(5, 1);
          t = 1;
          n = $urandom_range(3);
          m = $urandom_range(8);
          f = $urandom_range(DIST_MAX);
          low_burst_max = w + 8;  high_burst_max = 150;  items = 250;
        end
      endcase
      load_registers(w, t, n, m, f);
      if (ph == 5) begin
        // any phase reaches listening within four low ticks at these settings
        repeat (8) send_tick(1'b0);
        repeat (LONG_ECHO_TICKS) send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        steady <= 1'b0;
      end else begin
        run_random(items / 2);
        // sender hold-off mid pass: registers keep, state carries on
        if (ph == 0) drain_results();
        run_random(items - items / 2);
        if (ph == 4) steady <= 1'b0;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d echo ticks under %0d register settings, %0d measurements.",
             ticks_sent, settings_used, measurements);
    $display("Included zero and full-scale registers, shuffled bands, a long echo.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
